/* sv/srm_pkg.sv */
package srm_pkg;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned BitW   = 3;

  localparam logic [CountW-1:0] ReadyTimeoutReset = 16'd1000;
  localparam logic [AddrW-1:0]  AddrMask          = 6'h3F;
  localparam logic [ByteW-1:0]  HdrRead           = 8'h80;
  localparam logic [ByteW-1:0]  HdrStatus         = 8'hC0;
  localparam logic [BitW-1:0]   BitMsb            = 3'd7;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_WRITE  = 3'd1,
    FUNC_READ   = 3'd2,
    FUNC_STATUS = 3'd3,
    FUNC_STROBE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_HEAD_LO = 3'd2,
    PH_HEAD_HI = 3'd3,
    PH_DATA_LO = 3'd4,
    PH_DATA_HI = 3'd5
  } phase_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] reg_address;
    logic [ByteW-1:0] write_data;
    logic             miso_level;
  } req_t;

  typedef struct packed {
    logic             chip_select_n;
    logic             serial_clock;
    logic             master_out;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_data;
    logic             ready_timed_out;
  } res_t;

  function automatic logic [ByteW-1:0] header_byte(func_e kind, logic [AddrW-1:0] addr);
    logic [ByteW-1:0] h;
    h = {2'b00, addr & AddrMask};
    if (kind == FUNC_READ) begin
      h = h | HdrRead;
    end else if (kind == FUNC_STATUS) begin
      h = h | HdrStatus;
    end
    return h;
  endfunction

endpackage

/* sv/srm_req_if.sv */
interface srm_req_if import srm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [AddrW-1:0] reg_address;
  logic [ByteW-1:0] write_data;
  logic             miso_level;

  modport source (output valid, func, reg_address, write_data, miso_level, input ready);
  modport sink   (input valid, func, reg_address, write_data, miso_level, output ready);
endinterface

/* sv/srm_res_if.sv */
interface srm_res_if import srm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             chip_select_n;
  logic             serial_clock;
  logic             master_out;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] read_data;
  logic             ready_timed_out;

  modport source (output valid, chip_select_n, serial_clock, master_out, busy_res, done_res,
                  read_data, ready_timed_out, input ready);
  modport sink   (input valid, chip_select_n, serial_clock, master_out, busy_res, done_res,
                  read_data, ready_timed_out, output ready);
endinterface

/* sv/srm_cfg_if.sv */
interface srm_cfg_if import srm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] ready_timeout;

  modport source (output valid, ready_timeout, input ready);
  modport sink   (input valid, ready_timeout, output ready);
endinterface

/* sv/srm_core.sv */
module srm_core import srm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  req_t              req_i,
  input  logic [CountW-1:0] ready_timeout_i,
  output res_t              res_o
);

  phase_e            phase_q, phase_d;
  func_e             kind_q, kind_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic [ByteW-1:0]  out_shift_q, out_shift_d;
  logic [ByteW-1:0]  in_shift_q, in_shift_d;
  logic [ByteW-1:0]  held_q, held_d;
  logic [CountW-1:0] wait_q, wait_d;
  logic              tflag_q, tflag_d;
  logic [ByteW-1:0]  last_read_q, last_read_d;
  logic              done;
  logic              reading;
  logic              start;

  assign reading = (kind_q == FUNC_READ) || (kind_q == FUNC_STATUS);
  assign start   = (req_i.func == FUNC_WRITE) || (req_i.func == FUNC_READ) ||
                   (req_i.func == FUNC_STATUS) || (req_i.func == FUNC_STROBE);

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    bit_d       = bit_q;
    out_shift_d = out_shift_q;
    in_shift_d  = in_shift_q;
    held_d      = held_q;
    wait_d      = wait_q;
    tflag_d     = tflag_q;
    last_read_d = last_read_q;
    done        = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start) begin
          kind_d      = func_e'(req_i.func);
          held_d      = req_i.write_data;
          out_shift_d = header_byte(func_e'(req_i.func), req_i.reg_address);
          wait_d      = '0;
          bit_d       = BitMsb;
          phase_d     = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!req_i.miso_level) begin
          tflag_d = 1'b0;
          bit_d   = BitMsb;
          phase_d = PH_HEAD_LO;
        end else if (wait_q >= ready_timeout_i) begin
          tflag_d = 1'b1;
          bit_d   = BitMsb;
          phase_d = PH_HEAD_LO;
        end else begin
          wait_d = wait_q + 16'd1;
        end
      end
      PH_HEAD_LO: begin
        phase_d = PH_HEAD_HI;
      end
      PH_HEAD_HI: begin
        if (bit_q != '0) begin
          bit_d   = bit_q - 3'd1;
          phase_d = PH_HEAD_LO;
        end else if (kind_q == FUNC_WRITE) begin
          out_shift_d = held_q;
          bit_d       = BitMsb;
          phase_d     = PH_DATA_LO;
        end else if (reading) begin
          out_shift_d = '0;
          in_shift_d  = '0;
          bit_d       = BitMsb;
          phase_d     = PH_DATA_LO;
        end else begin
          bit_d   = BitMsb;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_DATA_LO: begin
        phase_d = PH_DATA_HI;
      end
      PH_DATA_HI: begin
        if (reading) begin
          in_shift_d = in_shift_q | (ByteW'(req_i.miso_level) << bit_q);
        end
        if (bit_q != '0) begin
          bit_d   = bit_q - 3'd1;
          phase_d = PH_DATA_LO;
        end else begin
          // The byte is complete once the last high half has been sampled.
          if (reading) begin
            last_read_d = in_shift_d;
          end
          bit_d   = BitMsb;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.chip_select_n   = (phase_d == PH_IDLE);
    res_o.serial_clock    = (phase_d == PH_HEAD_HI) || (phase_d == PH_DATA_HI);
    res_o.master_out      = ((phase_d != PH_IDLE) && (phase_d != PH_WAIT)) ?
                            out_shift_d[bit_d] : 1'b0;
    res_o.busy_res        = (phase_d != PH_IDLE);
    res_o.done_res        = done;
    res_o.read_data       = last_read_d;
    res_o.ready_timed_out = tflag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      kind_q      <= FUNC_TICK;
      bit_q       <= BitMsb;
      out_shift_q <= '0;
      in_shift_q  <= '0;
      held_q      <= '0;
      wait_q      <= '0;
      tflag_q     <= 1'b0;
      last_read_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      bit_q       <= bit_d;
      out_shift_q <= out_shift_d;
      in_shift_q  <= in_shift_d;
      held_q      <= held_d;
      wait_q      <= wait_d;
      tflag_q     <= tflag_d;
      last_read_q <= last_read_d;
    end
  end

`ifndef ASSERT_OFF
  a_start_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PH_IDLE) && (req_i.func == FUNC_WRITE) |=> (phase_q == PH_WAIT))
    else $error("write request from idle did not enter the wait phase");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> (phase_q == PH_IDLE) && (bit_q == BitMsb))
    else $error("finished transaction did not return to idle");

  a_half_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PH_HEAD_LO) |=> (phase_q == PH_HEAD_HI) && $stable(bit_q))
    else $error("low half of a header bit not followed by its high half");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(bit_q) && $stable(wait_q))
    else $error("state moved without an item");
`endif

endmodule

/* sv/spi_radio_register_access_master_top.sv */
// Channel   Dir   Fields
// cfg_i     in    ready_timeout (16)
// req_i     in    func (3), reg_address (6), write_data (8), miso_level (1)
// res_o     out   chip_select_n, serial_clock, master_out, busy_res, done_res,
//                 read_data (8), ready_timed_out
//
// Each request item is one half-bit tick and yields exactly one result item.
// An item passes through the input register and then the result register;
// the state update sits between them, so one item is taken every cycle unless the result stalls.
// Reset puts the bus idle (chip select high) with a timeout of 1000 ticks.
// A stalled result holds the input register, which then drops req_i.ready.
module spi_radio_register_access_master_top import srm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  srm_cfg_if.sink   cfg_i,
  srm_req_if.sink   req_i,
  srm_res_if.source res_o
);

  logic [CountW-1:0] ready_timeout_q;
  req_t              req_q;
  logic              req_valid_q;
  res_t              res_q;
  res_t              res_d;
  logic              res_valid_q;
  logic              step;

  assign step        = req_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !req_valid_q || step;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_timeout_q <= ReadyTimeoutReset;
    end else if (cfg_i.valid) begin
      ready_timeout_q <= cfg_i.ready_timeout;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.func        <= req_i.func;
      req_q.reg_address <= req_i.reg_address;
      req_q.write_data  <= req_i.write_data;
      req_q.miso_level  <= req_i.miso_level;
    end
  end

  srm_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .req_i           (req_q),
    .ready_timeout_i (ready_timeout_q),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.chip_select_n   = res_q.chip_select_n;
  assign res_o.serial_clock    = res_q.serial_clock;
  assign res_o.master_out      = res_q.master_out;
  assign res_o.busy_res        = res_q.busy_res;
  assign res_o.done_res        = res_q.done_res;
  assign res_o.read_data       = res_q.read_data;
  assign res_o.ready_timed_out = res_q.ready_timed_out;

endmodule
